/* rtl/hrp_pkg.sv */
// Shared types, character constants and name tables for the HTTP request header parser.
// Used by hrp_hdr_matcher and http_request_header_parser; no dependencies.
package hrp_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam int HDR_HOST   = 0;
    localparam int HDR_AGENT  = 1;
    localparam int HDR_ACCEPT = 2;

    localparam logic [2:0] METH_LEN [3] = '{3'd4, 3'd3, 3'd4};
    localparam logic [3:0] HDR_LEN  [3] = '{4'd4, 4'd10, 4'd6};
    localparam logic [3:0] VER_LEN      = 4'd8;

    localparam logic [1:0] METHOD_UNKNOWN  = 2'd3;
    localparam logic [1:0] VERSION_ILLEGAL = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  method_code;
        logic [1:0]  version_code;
        logic        host_found;
        logic [11:0] host_start;
        logic [9:0]  host_length;
        logic        agent_found;
        logic [11:0] agent_start;
        logic [9:0]  agent_length;
        logic        accept_found;
        logic [11:0] accept_start;
        logic [9:0]  accept_length;
        logic        blank_line_seen;
    } out_item_t;

    typedef struct packed {
        logic        found;
        logic [11:0] start;
        logic [9:0]  length;
    } hdr_result_t;

    function automatic logic [7:0] meth_char(input logic [1:0] c, input logic [1:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (c)
            2'd0:
            begin
                unique case (i)
                    2'd0: ch = "H";
                    2'd1: ch = "E";
                    2'd2: ch = "A";
                    default: ch = "D";
                endcase
            end
            2'd1:
            begin
                unique case (i)
                    2'd0: ch = "G";
                    2'd1: ch = "E";
                    2'd2: ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            2'd2:
            begin
                unique case (i)
                    2'd0: ch = "P";
                    2'd1: ch = "O";
                    2'd2: ch = "S";
                    default: ch = "T";
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] ver_char(input logic [1:0] c, input logic [2:0] i);
        logic [7:0] ch;
        unique case (i)
            3'd0: ch = "H";
            3'd1: ch = "T";
            3'd2: ch = "T";
            3'd3: ch = "P";
            3'd4: ch = "/";
            3'd5: ch = (c == 2'd2) ? "2" : "1";
            3'd6: ch = ".";
            default: ch = (c == 2'd1) ? "1" : "0";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] hdr_char(input int sel, input logic [3:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        if (sel == HDR_HOST)
        begin
            unique case (i)
                4'd0: ch = "H";
                4'd1: ch = "o";
                4'd2: ch = "s";
                4'd3: ch = "t";
                default: ch = 8'h00;
            endcase
        end
        else if (sel == HDR_AGENT)
        begin
            unique case (i)
                4'd0: ch = "U";
                4'd1: ch = "s";
                4'd2: ch = "e";
                4'd3: ch = "r";
                4'd4: ch = "-";
                4'd5: ch = "A";
                4'd6: ch = "g";
                4'd7: ch = "e";
                4'd8: ch = "n";
                4'd9: ch = "t";
                default: ch = 8'h00;
            endcase
        end
        else
        begin
            unique case (i)
                4'd0: ch = "A";
                4'd1: ch = "c";
                4'd2: ch = "c";
                4'd3: ch = "e";
                4'd4: ch = "p";
                4'd5: ch = "t";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

/* rtl/hrp_hdr_matcher.sv */
// One header-name matcher: finds the first occurrence of a name, skips separators,
// then records value offset and length. Depends on hrp_pkg.
module hrp_hdr_matcher #(
    parameter int HDR_SEL   = 0,
    parameter int POS_W     = 12,
    parameter int LEN_W     = 10,
    parameter int VALUE_MAX = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                clear,
    input  logic [7:0]          data_byte,
    input  logic [POS_W-1:0]    pos,
    output hrp_pkg::hdr_result_t result
);

    typedef enum logic [1:0] {SEARCH, SKIP, VALUE, DONE} status_t;

    localparam logic [3:0]       NAME_LEN = hrp_pkg::HDR_LEN[HDR_SEL];
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(VALUE_MAX - 1);

    status_t            status_reg, status_next;
    logic [3:0]         idx_reg, idx_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [LEN_W-1:0]   len_reg, len_next;

    logic               is_term;
    logic [3:0]         idx_cur;
    logic [POS_W+11:0]  start_ext;
    logic [LEN_W+9:0]   len_ext;
    logic               has_val;

    assign is_term = (data_byte == hrp_pkg::CH_CR) || (data_byte == hrp_pkg::CH_LF) ||
                     (data_byte == hrp_pkg::CH_SEMI) || (data_byte == hrp_pkg::CH_SP);

    always_comb
    begin
        status_next = status_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        idx_cur     = (idx_reg >= NAME_LEN) ? 4'd0 : idx_reg;
        if (step)
        begin
            unique case (status_reg)
                SEARCH:
                begin
                    if (data_byte == hrp_pkg::hdr_char(HDR_SEL, idx_cur))
                        idx_next = idx_cur + 4'd1;
                    else if (data_byte == hrp_pkg::hdr_char(HDR_SEL, 4'd0))
                        idx_next = 4'd1;
                    else
                        idx_next = 4'd0;
                    if (idx_next >= NAME_LEN)
                    begin
                        status_next = SKIP;
                        idx_next    = 4'd0;
                    end
                end
                SKIP:
                begin
                    if (!(data_byte == hrp_pkg::CH_COLON || data_byte == hrp_pkg::CH_SP))
                    begin
                        start_next = pos;
                        if (is_term)
                        begin
                            len_next    = '0;
                            status_next = DONE;
                        end
                        else
                        begin
                            len_next    = LEN_W'(1);
                            status_next = VALUE;
                        end
                    end
                end
                VALUE:
                begin
                    if (is_term)
                        status_next = DONE;
                    else if (len_reg < LEN_MAX)
                        len_next = len_reg + LEN_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Result reflects the state after the current byte.
    assign has_val   = (status_next == VALUE) || (status_next == DONE);
    assign start_ext = {12'd0, start_next};
    assign len_ext   = {10'd0, len_next};

    always_comb
    begin
        result.found  = (status_next != SEARCH);
        result.start  = has_val ? start_ext[11:0] : 12'd0;
        result.length = has_val ? len_ext[9:0] : 10'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= SEARCH;
            idx_reg    <= 4'd0;
            start_reg  <= '0;
            len_reg    <= '0;
        end
        else if (clear)
        begin
            status_reg <= SEARCH;
            idx_reg    <= 4'd0;
            start_reg  <= '0;
            len_reg    <= '0;
        end
        else
        begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
        end
    end

endmodule

/* rtl/http_request_header_parser.sv */
// HTTP request header parser: one byte per request, one summary per message.
// The last byte passes the input register, then the summary register drives sum_valid.
// Throughput: one byte per cycle, unless a last byte waits for a held summary.
// Reset: rst_n (async, low) clears all parse state and both stages' valid flags;
// parse state also returns to reset after each message's last byte.
// Depends on hrp_pkg and hrp_hdr_matcher.
module http_request_header_parser #(
    parameter int MESSAGE_BYTES = 4096,
    parameter int VALUE_MAX     = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hrp_pkg::in_item_t  req_data,
    output logic               sum_valid,
    input  logic               sum_ready,
    output hrp_pkg::out_item_t sum_data
);

    localparam int POS_W = $clog2(MESSAGE_BYTES);
    localparam int LEN_W = $clog2(VALUE_MAX);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MESSAGE_BYTES - 1);

    typedef enum logic [2:0] {METHOD, PATH, VERSION, HEADERS, BODY} phase_t;

    // input stage
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eom_reg;
    logic               out_free;
    logic               fire;

    // parse state
    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [2:0]         mflags_reg, mflags_next;
    logic [2:0]         midx_reg, midx_next;
    logic [2:0]         vflags_reg, vflags_next;
    logic [3:0]         vidx_reg, vidx_next;
    logic [1:0]         lend_reg, lend_next;

    logic               sum_valid_reg;
    hrp_pkg::out_item_t sum_data_reg;
    hrp_pkg::out_item_t result;
    logic [1:0]         mcls, vcls;
    logic               hdr_step, clear;
    hrp_pkg::hdr_result_t host_res, agent_res, accept_res;

    assign out_free  = !sum_valid_reg || sum_ready;
    assign fire      = in_valid_reg && (!in_eom_reg || out_free);
    assign req_ready = !in_valid_reg || fire;
    assign hdr_step  = fire && (phase_reg == HEADERS);
    assign clear     = fire && in_eom_reg;
    assign sum_valid = sum_valid_reg;
    assign sum_data  = sum_data_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        mflags_next = mflags_reg;
        midx_next   = midx_reg;
        vflags_next = vflags_reg;
        vidx_next   = vidx_reg;
        lend_next   = lend_reg;
        pos_next    = (pos_reg != POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;
        unique case (phase_reg)
            METHOD:
            begin
                if (in_byte_reg == hrp_pkg::CH_SP)
                    phase_next = PATH;
                else
                begin
                    for (int c = 0; c < 3; c++)
                        if (midx_reg < hrp_pkg::METH_LEN[c] &&
                            in_byte_reg != hrp_pkg::meth_char(2'(c), midx_reg[1:0]))
                            mflags_next[c] = 1'b0;
                    if (midx_reg != 3'd7)
                        midx_next = midx_reg + 3'd1;
                end
            end
            PATH:
            begin
                if (in_byte_reg == hrp_pkg::CH_SP)
                    phase_next = VERSION;
            end
            VERSION:
            begin
                if (in_byte_reg == hrp_pkg::CH_CR || in_byte_reg == hrp_pkg::CH_SP)
                begin
                    phase_next = HEADERS;
                    lend_next  = (in_byte_reg == hrp_pkg::CH_CR) ? 2'd1 : 2'd0;
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                        if (vidx_reg < hrp_pkg::VER_LEN &&
                            in_byte_reg != hrp_pkg::ver_char(2'(c), vidx_reg[2:0]))
                            vflags_next[c] = 1'b0;
                    if (vidx_reg != 4'd15)
                        vidx_next = vidx_reg + 4'd1;
                end
            end
            HEADERS:
            begin
                // track CR LF CR LF
                if (in_byte_reg == hrp_pkg::CH_CR)
                    lend_next = (lend_reg == 2'd2) ? 2'd3 : 2'd1;
                else if (in_byte_reg == hrp_pkg::CH_LF)
                begin
                    if (lend_reg == 2'd3)
                    begin
                        lend_next  = 2'd0;
                        phase_next = BODY;
                    end
                    else
                        lend_next = (lend_reg == 2'd1) ? 2'd2 : 2'd0;
                end
                else
                    lend_next = 2'd0;
            end
            default: ;
        endcase
    end

    // classify from post-byte state; lowest candidate wins
    always_comb
    begin
        mcls = hrp_pkg::METHOD_UNKNOWN;
        vcls = hrp_pkg::VERSION_ILLEGAL;
        for (int c = 2; c >= 0; c--)
        begin
            if (mflags_next[c] && midx_next >= hrp_pkg::METH_LEN[c])
                mcls = 2'(c);
            if (vflags_next[c] && vidx_next >= hrp_pkg::VER_LEN)
                vcls = 2'(c);
        end
    end

    hrp_hdr_matcher #(
        .HDR_SEL   (hrp_pkg::HDR_HOST),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W),
        .VALUE_MAX (VALUE_MAX)
    ) u_host (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (hdr_step),
        .clear     (clear),
        .data_byte (in_byte_reg),
        .pos       (pos_reg),
        .result    (host_res)
    );

    hrp_hdr_matcher #(
        .HDR_SEL   (hrp_pkg::HDR_AGENT),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W),
        .VALUE_MAX (VALUE_MAX)
    ) u_agent (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (hdr_step),
        .clear     (clear),
        .data_byte (in_byte_reg),
        .pos       (pos_reg),
        .result    (agent_res)
    );

    hrp_hdr_matcher #(
        .HDR_SEL   (hrp_pkg::HDR_ACCEPT),
        .POS_W     (POS_W),
        .LEN_W     (LEN_W),
        .VALUE_MAX (VALUE_MAX)
    ) u_accept (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (hdr_step),
        .clear     (clear),
        .data_byte (in_byte_reg),
        .pos       (pos_reg),
        .result    (accept_res)
    );

    always_comb
    begin
        result.method_code     = mcls;
        result.version_code    = vcls;
        result.host_found      = host_res.found;
        result.host_start      = host_res.start;
        result.host_length     = host_res.length;
        result.agent_found     = agent_res.found;
        result.agent_start     = agent_res.start;
        result.agent_length    = agent_res.length;
        result.accept_found    = accept_res.found;
        result.accept_start    = accept_res.start;
        result.accept_length   = accept_res.length;
        result.blank_line_seen = (phase_next == BODY);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            phase_reg     <= METHOD;
            pos_reg       <= '0;
            mflags_reg    <= 3'b111;
            midx_reg      <= 3'd0;
            vflags_reg    <= 3'b111;
            vidx_reg      <= 4'd0;
            lend_reg      <= 2'd0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= req_data.data_byte;
                in_eom_reg   <= req_data.end_of_message;
            end
            else if (fire)
                in_valid_reg <= 1'b0;

            if (clear)
            begin
                sum_valid_reg <= 1'b1;
                sum_data_reg  <= result;
            end
            else if (sum_ready)
                sum_valid_reg <= 1'b0;

            if (clear)
            begin
                // last byte: start the next message from reset
                phase_reg  <= METHOD;
                pos_reg    <= '0;
                mflags_reg <= 3'b111;
                midx_reg   <= 3'd0;
                vflags_reg <= 3'b111;
                vidx_reg   <= 4'd0;
                lend_reg   <= 2'd0;
            end
            else if (fire)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                mflags_reg <= mflags_next;
                midx_reg   <= midx_next;
                vflags_reg <= vflags_next;
                vidx_reg   <= vidx_next;
                lend_reg   <= lend_next;
            end
        end
    end

endmodule
